FILE: hw/rtl/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine: buffer geometry,
// command codes, the one-hot phase encoding and the stage payload structs.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   // Byte buffer geometry. Index registers can hold the depth itself.
   localparam int BufDepth = 16;
   localparam int AddrW    = (BufDepth > 1) ? $clog2(BufDepth) : 1;
   localparam int IdxW     = $clog2(BufDepth + 1);
   localparam int PendW    = 5;
   localparam int WideW    = (IdxW > 5) ? IdxW : 5;

   // Command codes carried in the op field of a request.
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_OPEN_W = 3'd1;
   localparam logic [2:0] OP_PUSH   = 3'd2;
   localparam logic [2:0] OP_LAUNCH = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;
   localparam logic [2:0] OP_POP    = 3'd5;

   typedef enum logic [13:0] {
      PH_IDLE   = 14'h0001,
      PH_S_SDA  = 14'h0002,
      PH_S_SCL  = 14'h0004,
      PH_W_SET  = 14'h0008,
      PH_W_HIGH = 14'h0010,
      PH_A_SET  = 14'h0020,
      PH_A_HIGH = 14'h0040,
      PH_R_LOW  = 14'h0080,
      PH_R_HIGH = 14'h0100,
      PH_K_SET  = 14'h0200,
      PH_K_HIGH = 14'h0400,
      PH_P_LOW  = 14'h0800,
      PH_P_SCL  = 14'h1000,
      PH_P_SDA  = 14'h2000
   } phase_type;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] dev_addr;
      logic [7:0] wr_byte;
      logic [3:0] rd_count;
      logic       sda_sense;
      logic       scl_sense;
   } req_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_level;
      logic             sda_drive;
      logic             busy_res;
      logic             got_nack;
      logic [7:0]       pop_byte;
      logic [PendW-1:0] pending;
   } rsp_type;

endpackage

FILE: hw/rtl/i2cmbe_req_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_req_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module i2cmbe_req_stage
   import i2cmbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    advance,
   output logic    stage_valid,
   output req_type stage_data
);

   logic    vld_ff;
   logic    vld_in;
   req_type data_ff;

   // The stage frees up whenever its request moves on to the core.
   assign req_ready = !vld_ff || advance;
   assign vld_in    = req_ready ? req_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign stage_valid = vld_ff;
   assign stage_data  = data_ff;

endmodule

FILE: hw/rtl/i2cmbe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer and byte buffer. Processes one request per cycle while fire
// is high, and yields the result fields computed from the updated state.
// ----------------------------------------------------------------------------
module i2cmbe_core
   import i2cmbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   phase_type        phase_ff, phase_in;
   logic [2:0]       bit_ff, bit_in;
   logic [7:0]       shift_ff, shift_in;
   logic [IdxW-1:0]  fill_ff, fill_in;
   logic [IdxW-1:0]  drain_ff, drain_in;
   logic [IdxW-1:0]  rend_ff, rend_in;
   logic             is_read_ff, is_read_in;
   logic             nack_ff, nack_in;
   logic             scl_ff, scl_in;
   logic             sda_ff, sda_in;
   logic             drv_ff, drv_in;

   logic [7:0]       store [BufDepth];
   logic             store_we;
   logic [AddrW-1:0] store_waddr;
   logic [7:0]       store_wdata;

   logic [7:0]       rd_data;
   logic             drain_ok;
   logic             fill_ok;
   logic [7:0]       popped;
   logic [7:0]       rx_byte;
   logic [2:0]       bit_inc;
   logic             last_byte;
   logic [WideW-1:0] cnt_wide;
   logic             pin_scl, pin_sda, pin_drv;
   logic [IdxW-1:0]  pend_raw;

   assign drain_ok  = drain_ff < IdxW'(BufDepth);
   assign fill_ok   = fill_ff < IdxW'(BufDepth);
   assign rd_data   = drain_ok ? store[drain_ff[AddrW-1:0]] : 8'h00;
   assign rx_byte   = {shift_ff[6:0], req.sda_sense};
   assign bit_inc   = bit_ff + 3'd1;
   assign last_byte = fill_ff >= rend_ff;
   assign cnt_wide  = WideW'(req.rd_count) + WideW'(1);

   always_comb begin
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      fill_in     = fill_ff;
      drain_in    = drain_ff;
      rend_in     = rend_ff;
      is_read_in  = is_read_ff;
      nack_in     = nack_ff;
      pin_scl     = scl_ff;
      pin_sda     = sda_ff;
      pin_drv     = drv_ff;
      store_we    = 1'b0;
      store_waddr = fill_ff[AddrW-1:0];
      store_wdata = req.wr_byte;
      popped      = 8'h00;

      if (fire) begin
         if (req.op == OP_TICK) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  pin_scl = 1'b1; pin_sda = 1'b1; pin_drv = 1'b1;
               end
               PH_S_SDA: begin
                  pin_scl = 1'b1; pin_sda = 1'b0; pin_drv = 1'b1;
                  phase_in = PH_S_SCL;
               end
               PH_S_SCL: begin
                  pin_scl = 1'b0; pin_sda = 1'b0; pin_drv = 1'b1;
                  shift_in = rd_data;
                  drain_in = drain_ff + IdxW'(1);
                  bit_in   = 3'd0;
                  phase_in = PH_W_SET;
               end
               PH_W_SET: begin
                  pin_scl = 1'b0; pin_sda = shift_ff[7]; pin_drv = 1'b1;
                  phase_in = PH_W_HIGH;
               end
               PH_W_HIGH: begin
                  pin_scl = 1'b1; pin_sda = shift_ff[7]; pin_drv = 1'b1;
                  // A slave holding SCL low stretches this step.
                  if (req.scl_sense) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_inc;
                     phase_in = (bit_inc == 3'd0) ? PH_A_SET : PH_W_SET;
                  end
               end
               PH_A_SET: begin
                  pin_scl = 1'b0; pin_sda = 1'b0; pin_drv = 1'b0;
                  phase_in = PH_A_HIGH;
               end
               PH_A_HIGH: begin
                  pin_scl = 1'b1; pin_sda = 1'b0; pin_drv = 1'b0;
                  nack_in = req.sda_sense;
                  if (req.sda_sense) begin
                     phase_in = PH_P_LOW;
                  end else if (is_read_ff) begin
                     bit_in   = 3'd0;
                     shift_in = 8'h00;
                     phase_in = (fill_ff < rend_ff) ? PH_R_LOW : PH_P_LOW;
                  end else if (drain_ff < fill_ff) begin
                     shift_in = rd_data;
                     drain_in = drain_ff + IdxW'(1);
                     bit_in   = 3'd0;
                     phase_in = PH_W_SET;
                  end else begin
                     phase_in = PH_P_LOW;
                  end
               end
               PH_R_LOW: begin
                  pin_scl = 1'b0; pin_sda = 1'b0; pin_drv = 1'b0;
                  phase_in = PH_R_HIGH;
               end
               PH_R_HIGH: begin
                  pin_scl = 1'b1; pin_sda = 1'b0; pin_drv = 1'b0;
                  shift_in = rx_byte;
                  bit_in   = bit_inc;
                  if (bit_inc == 3'd0) begin
                     if (fill_ok) begin
                        store_we    = 1'b1;
                        store_wdata = rx_byte;
                        fill_in     = fill_ff + IdxW'(1);
                     end
                     phase_in = PH_K_SET;
                  end else begin
                     phase_in = PH_R_LOW;
                  end
               end
               PH_K_SET: begin
                  // The final byte of a read is answered with NACK.
                  pin_scl = 1'b0; pin_sda = last_byte; pin_drv = 1'b1;
                  phase_in = PH_K_HIGH;
               end
               PH_K_HIGH: begin
                  pin_scl = 1'b1; pin_sda = last_byte; pin_drv = 1'b1;
                  bit_in   = 3'd0;
                  shift_in = 8'h00;
                  phase_in = last_byte ? PH_P_LOW : PH_R_LOW;
               end
               PH_P_LOW: begin
                  pin_scl = 1'b0; pin_sda = 1'b0; pin_drv = 1'b1;
                  phase_in = PH_P_SCL;
               end
               PH_P_SCL: begin
                  pin_scl = 1'b1; pin_sda = 1'b0; pin_drv = 1'b1;
                  phase_in = PH_P_SDA;
               end
               PH_P_SDA: begin
                  pin_scl = 1'b1; pin_sda = 1'b1; pin_drv = 1'b1;
                  phase_in = PH_IDLE;
               end
               default: begin
                  pin_scl = 1'b1; pin_sda = 1'b1; pin_drv = 1'b1;
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (phase_ff == PH_IDLE) begin
            unique case (req.op)
               OP_OPEN_W: begin
                  store_we    = 1'b1;
                  store_waddr = '0;
                  store_wdata = {req.dev_addr, 1'b0};
                  fill_in     = IdxW'(1);
                  drain_in    = '0;
                  is_read_in  = 1'b0;
               end
               OP_PUSH: begin
                  if (fill_ok) begin
                     store_we = 1'b1;
                     fill_in  = fill_ff + IdxW'(1);
                  end
               end
               OP_LAUNCH: begin
                  if (fill_ff != '0) begin
                     is_read_in = 1'b0;
                     nack_in    = 1'b0;
                     drain_in   = '0;
                     phase_in   = PH_S_SDA;
                  end
               end
               OP_READ: begin
                  rend_in = (cnt_wide > WideW'(BufDepth)) ? IdxW'(BufDepth)
                                                          : IdxW'(cnt_wide);
                  store_we    = 1'b1;
                  store_waddr = '0;
                  store_wdata = {req.dev_addr, 1'b1};
                  fill_in     = IdxW'(1);
                  drain_in    = '0;
                  is_read_in  = 1'b1;
                  nack_in     = 1'b0;
                  phase_in    = PH_S_SDA;
               end
               OP_POP: begin
                  if ((drain_ff < fill_ff) && drain_ok) begin
                     popped   = rd_data;
                     drain_in = drain_ff + IdxW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign scl_in   = pin_scl;
   assign drv_in   = pin_drv;
   assign sda_in   = pin_drv & pin_sda;
   assign pend_raw = fill_in - drain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'h00;
         fill_ff    <= '0;
         drain_ff   <= '0;
         rend_ff    <= '0;
         is_read_ff <= 1'b0;
         nack_ff    <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         drv_ff     <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         fill_ff    <= fill_in;
         drain_ff   <= drain_in;
         rend_ff    <= rend_in;
         is_read_ff <= is_read_in;
         nack_ff    <= nack_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         drv_ff     <= drv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[store_waddr] <= store_wdata;
      end
   end

   always_comb begin
      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.sda_drive = drv_in;
      rsp.busy_res  = phase_in != PH_IDLE;
      rsp.got_nack  = nack_in;
      rsp.pop_byte  = popped;
      rsp.pending   = PendW'(pend_raw);
   end

endmodule

FILE: hw/rtl/i2cmbe_rsp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_rsp_stage
// Output register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cmbe_rsp_stage
   import i2cmbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    vld_ff;
   logic    vld_in;
   rsp_type data_ff;

   assign advance = !vld_ff || rsp_ready;
   assign vld_in  = advance ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hw/rtl/i2c_master_bit_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master with a byte buffer; each tick request steps the SCL/SDA pins.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  req_*    in         req_valid/req_ready  op, dev_addr, wr_byte, rd_count,
//                                           sda_sense, scl_sense
//  rsp_*    out        rsp_valid/rsp_ready  pin drive, busy, nack, pop_byte,
//                                           pending
//
//  One request per cycle while the output is not stalled; a request is
//  registered in the input stage, its result in the output stage, where it
//  can be taken. Sequencer and buffer update at the edge that registers it.
//  Synchronous reset returns the bus to released and empties the buffer.
//  A stalled result holds the pipeline; req_ready stays high while the
//  output register is empty or being drained.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit
   import i2cmbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_op,
   input  logic [6:0]       req_dev_addr,
   input  logic [7:0]       req_wr_byte,
   input  logic [3:0]       req_rd_count,
   input  logic             req_sda_sense,
   input  logic             req_scl_sense,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_sda_drive,
   output logic             rsp_busy_res,
   output logic             rsp_got_nack,
   output logic [7:0]       rsp_pop_byte,
   output logic [PendW-1:0] rsp_pending
);

   req_type req_data;
   req_type stage_data;
   logic    stage_valid;
   logic    advance;
   logic    fire;
   rsp_type core_rsp;
   rsp_type out_data;

   always_comb begin
      req_data.op        = req_op;
      req_data.dev_addr  = req_dev_addr;
      req_data.wr_byte   = req_wr_byte;
      req_data.rd_count  = req_rd_count;
      req_data.sda_sense = req_sda_sense;
      req_data.scl_sense = req_scl_sense;
   end

   assign fire = stage_valid && advance;

   i2cmbe_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   i2cmbe_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (stage_data),
      .rsp   (core_rsp)
   );

   i2cmbe_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_data   (core_rsp),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_data)
   );

   assign rsp_scl_level = out_data.scl_level;
   assign rsp_sda_level = out_data.sda_level;
   assign rsp_sda_drive = out_data.sda_drive;
   assign rsp_busy_res  = out_data.busy_res;
   assign rsp_got_nack  = out_data.got_nack;
   assign rsp_pop_byte  = out_data.pop_byte;
   assign rsp_pending   = out_data.pending;

endmodule

FILE: hw/rtl/i2cmbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks on the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker
   import i2cmbe_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_scl_level,
   input logic             rsp_sda_level,
   input logic             rsp_sda_drive,
   input logic             rsp_busy_res,
   input logic [7:0]       rsp_pop_byte,
   input logic [PendW-1:0] rsp_pending
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_byte)
         && $stable(rsp_pending) && $stable(rsp_busy_res))
      else $error("stalled result changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With no result waiting, a new request is always taken.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // Between transactions the bus is released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl_level && rsp_sda_level && rsp_sda_drive)
      else $error("bus not released while idle");

   // Bytes can only be popped while no transaction runs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pop_byte != 8'h00) |-> !rsp_busy_res)
      else $error("pop returned data while busy");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_checker (.*);
